### design/imf_pkg.sv
// Shared types, direction codes and the saturation helper for the ideal MHD flux core.
// Stands alone; imported by ideal_mhd_flux_core.
package imf_pkg;

	// Normal direction codes held in the configuration register.
	localparam logic [1:0] DIR_X    = 2'd0;
	localparam logic [1:0] DIR_Y    = 2'd1;
	localparam logic [1:0] DIR_Z    = 2'd2;
	localparam logic [1:0] DIR_NONE = 2'd3;

	// Width of the wide sums before saturation; covers every fraction width in range.
	localparam int SUM_W = 66;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	// One input cell.
	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] field_x;
		logic signed [31:0] field_y;
		logic signed [31:0] field_z;
		logic signed [31:0] gas_pressure;
		logic signed [31:0] mom_x;
		logic signed [31:0] mom_y;
		logic signed [31:0] mom_z;
		logic signed [31:0] total_energy;
		logic               last_cell;
	} in_item_t;

	// One flux result.
	typedef struct packed {
		logic signed [31:0] flux_mass;
		logic signed [31:0] flux_mom_x;
		logic signed [31:0] flux_mom_y;
		logic signed [31:0] flux_mom_z;
		logic signed [31:0] flux_field_x;
		logic signed [31:0] flux_field_y;
		logic signed [31:0] flux_field_z;
		logic signed [31:0] flux_energy;
		logic signed [31:0] total_pressure;
		logic               overflow;
		logic               last_out;
	} out_item_t;

	// A saturated word together with its overflow mark.
	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	// Clamp a wide signed sum to the 32-bit signed range.
	function automatic sat_t sat_word(input logic signed [SUM_W-1:0] v);
		sat_t r;
		priority if (v > SAT_HI) begin
			r.ovf = 1'b1;
			r.val = SAT_HI[31:0];
		end else if (v < SAT_LO) begin
			r.ovf = 1'b1;
			r.val = SAT_LO[31:0];
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

### design/ideal_mhd_flux_core.sv
// Ideal MHD flux core: five-stage pipeline from one cell to its normal flux vector.
// Depends on imf_pkg for the item types, direction codes and saturation.
//
// Usage: cells arrive on the in_valid/in_ready request channel as one in_item_t each;
// flux results leave on out_valid/out_ready as one out_item_t each, in order.
// The normal direction is set through cfg_we/cfg_wdata (0 = x, 1 = y, 2 = z); a write
// of 3 is ignored. Write it only while no cell is in flight.
// Throughput: one cell per clock while the receiver takes results; every stage is a register with its own valid bit.
// Stage 1 registers the cell and picks the normal components, stage 2 holds nineteen
// 32x32 products, stage 3 the saturated sums, stage 4 the two products that use total
// pressure and v.B, stage 5 the energy flux and the output register.
// When the receiver stalls, the result holds in the output register and earlier stages
// keep filling their empty slots; in_ready drops only once every stage is full.
// Reset clears the valid bits and sets the direction to x; no clearing pass is needed.
// Results saturate to the 32-bit signed range and the overflow bit marks any clamp.
module ideal_mhd_flux_core
	import imf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	// Width of a product after the fraction shift, and of the half field squared.
	localparam int PW = 64 - FRAC_BITS;
	localparam int HW = 63 - FRAC_BITS;

	// Exact signed product, rounded toward minus infinity.
	function automatic logic signed [PW-1:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return PW'(p >>> FRAC_BITS);
	endfunction

	// Exact square; never negative, fits in 63 bits.
	function automatic logic [62:0] sqr(input logic signed [31:0] a);
		logic signed [63:0] p;
		p = a * a;
		return p[62:0];
	endfunction

	logic [1:0] dir_q;

	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Stage 1 registers.
	logic signed [31:0] vel_s1 [3];
	logic signed [31:0] fld_s1 [3];
	logic signed [31:0] mom_s1 [3];
	logic signed [31:0] prs_s1, eng_s1, vn_s1, bn_s1, momn_s1;
	logic [1:0]         dir_s1;
	logic               last_s1;

	// Stage 2 registers.
	logic [62:0]          sq_s2  [3];
	logic signed [PW-1:0] vbp_s2 [3];
	logic signed [PW-1:0] vm_s2  [3];
	logic signed [PW-1:0] bf_s2  [3];
	logic signed [PW-1:0] vf_s2  [3];
	logic signed [PW-1:0] bv_s2  [3];
	logic signed [PW-1:0] ev_s2;
	logic signed [31:0]   prs_s2, vn_s2, bn_s2, momn_s2;
	logic [1:0]           dir_s2;
	logic                 last_s2;

	// Stage 3 registers.
	logic signed [31:0]   ptot_s3, vb_s3, vn_s3, bn_s3, momn_s3;
	logic signed [31:0]   fm_s3 [3];
	logic signed [31:0]   fb_s3 [3];
	logic signed [PW-1:0] ev_s3;
	logic [1:0]           dir_s3;
	logic                 last_s3, ovf_s3;

	// Stage 4 registers.
	logic signed [PW-1:0] ev_s4, pv_s4, bvb_s4;
	logic signed [31:0]   ptot_s4, momn_s4;
	logic signed [31:0]   fm_s4 [3];
	logic signed [31:0]   fb_s4 [3];
	logic [1:0]           dir_s4;
	logic                 last_s4, ovf_s4;

	// Stage 5: output register.
	out_item_t  out_s5;
	logic [1:0] dir_s5;

	// Direction register; the unused code is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_X;
		end else if (cfg_we && cfg_wdata != DIR_NONE) begin
			dir_q <= cfg_wdata;
		end
	end

	// A stage loads when it is empty or its content moves on.
	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: pick the normal components and register the cell.
	logic signed [31:0] vn_in, bn_in, momn_in;

	always_comb begin
		unique case (dir_q)
			DIR_Y: begin
				vn_in   = in_item.vel_y;
				bn_in   = in_item.field_y;
				momn_in = in_item.mom_y;
			end
			DIR_Z: begin
				vn_in   = in_item.vel_z;
				bn_in   = in_item.field_z;
				momn_in = in_item.mom_z;
			end
			default: begin
				vn_in   = in_item.vel_x;
				bn_in   = in_item.field_x;
				momn_in = in_item.mom_x;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			vel_s1[0] <= in_item.vel_x;
			vel_s1[1] <= in_item.vel_y;
			vel_s1[2] <= in_item.vel_z;
			fld_s1[0] <= in_item.field_x;
			fld_s1[1] <= in_item.field_y;
			fld_s1[2] <= in_item.field_z;
			mom_s1[0] <= in_item.mom_x;
			mom_s1[1] <= in_item.mom_y;
			mom_s1[2] <= in_item.mom_z;
			prs_s1    <= in_item.gas_pressure;
			eng_s1    <= in_item.total_energy;
			vn_s1     <= vn_in;
			bn_s1     <= bn_in;
			momn_s1   <= momn_in;
			dir_s1    <= dir_q;
			last_s1   <= in_item.last_cell;
		end
	end

	// Stage 2: every product that depends only on the cell.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k]  <= sqr(fld_s1[k]);
				vbp_s2[k] <= mulq(vel_s1[k], fld_s1[k]);
				vm_s2[k]  <= mulq(vn_s1, mom_s1[k]);
				bf_s2[k]  <= mulq(bn_s1, fld_s1[k]);
				vf_s2[k]  <= mulq(vn_s1, fld_s1[k]);
				bv_s2[k]  <= mulq(bn_s1, vel_s1[k]);
			end
			ev_s2   <= mulq(eng_s1, vn_s1);
			prs_s2  <= prs_s1;
			vn_s2   <= vn_s1;
			bn_s2   <= bn_s1;
			momn_s2 <= momn_s1;
			dir_s2  <= dir_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: sums and saturation of total pressure, v.B and the flux terms.
	logic [63:0]          sq_sum;
	logic [HW-1:0]        half_sq;
	sat_t                 ptot_c, vb_c;
	sat_t                 fm_c [3];
	sat_t                 fb_c [3];
	logic                 ovf_c;

	always_comb begin
		sq_sum  = 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);
		half_sq = HW'(sq_sum >> (FRAC_BITS + 1));
		ptot_c  = sat_word(SUM_W'(prs_s2) + SUM_W'(half_sq));
		vb_c    = sat_word(SUM_W'(vbp_s2[0]) + SUM_W'(vbp_s2[1]) + SUM_W'(vbp_s2[2]));
		ovf_c   = ptot_c.ovf | vb_c.ovf;
		for (int k = 0; k < 3; k++) begin
			fm_c[k] = sat_word(SUM_W'(vm_s2[k]) - SUM_W'(bf_s2[k]));
			if (dir_s2 == 2'(k)) begin
				fb_c[k] = '0;
			end else begin
				fb_c[k] = sat_word(SUM_W'(vf_s2[k]) - SUM_W'(bv_s2[k]));
			end
			ovf_c = ovf_c | fm_c[k].ovf | fb_c[k].ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ptot_s3 <= ptot_c.val;
			vb_s3   <= vb_c.val;
			for (int k = 0; k < 3; k++) begin
				fm_s3[k] <= fm_c[k].val;
				fb_s3[k] <= fb_c[k].val;
			end
			ev_s3   <= ev_s2;
			vn_s3   <= vn_s2;
			bn_s3   <= bn_s2;
			momn_s3 <= momn_s2;
			dir_s3  <= dir_s2;
			last_s3 <= last_s2;
			ovf_s3  <= ovf_c;
		end
	end

	// Stage 4: products with the saturated total pressure and v.B.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			pv_s4   <= mulq(ptot_s3, vn_s3);
			bvb_s4  <= mulq(bn_s3, vb_s3);
			ev_s4   <= ev_s3;
			ptot_s4 <= ptot_s3;
			momn_s4 <= momn_s3;
			fm_s4   <= fm_s3;
			fb_s4   <= fb_s3;
			dir_s4  <= dir_s3;
			last_s4 <= last_s3;
			ovf_s4  <= ovf_s3;
		end
	end

	// Stage 5: energy flux and assembly of the result.
	sat_t e_c;

	assign e_c = sat_word(SUM_W'(ev_s4) + SUM_W'(pv_s4) - SUM_W'(bvb_s4));

	always_ff @(posedge clk) begin
		if (en_s5) begin
			out_s5.flux_mass      <= momn_s4;
			out_s5.flux_mom_x     <= fm_s4[0];
			out_s5.flux_mom_y     <= fm_s4[1];
			out_s5.flux_mom_z     <= fm_s4[2];
			out_s5.flux_field_x   <= fb_s4[0];
			out_s5.flux_field_y   <= fb_s4[1];
			out_s5.flux_field_z   <= fb_s4[2];
			out_s5.flux_energy    <= e_c.val;
			out_s5.total_pressure <= ptot_s4;
			out_s5.overflow       <= ovf_s4 | e_c.ovf;
			out_s5.last_out       <= last_s4;
			dir_s5                <= dir_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_item  = out_s5;

`ifndef SYNTHESIS
	// The direction register never takes the unused code.
	a_dir_legal: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q != DIR_NONE)
		else $error("direction register holds the unused code");

	// An empty first stage always takes a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

	// The induction flux along the normal is zero.
	a_normal_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((dir_s5 == DIR_X && out_item.flux_field_x == 32'sd0) ||
			(dir_s5 == DIR_Y && out_item.flux_field_y == 32'sd0) ||
			(dir_s5 == DIR_Z && out_item.flux_field_z == 32'sd0)))
		else $error("normal induction flux is not zero");

	// A held middle stage keeps its contents.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_s4) |=> (v_s3 && $stable(ptot_s3) && $stable(ovf_s3)))
		else $error("stage 3 changed while stalled");
`endif

endmodule

### tb/ideal_mhd_flux_core_tb.sv
// Self-checking testbench for the ideal MHD flux core: directed table, then random cells.
// Needs imf_pkg and ideal_mhd_flux_core; each result is compared with a local flux predictor.
// Covers all three normal directions, ignored writes, idle and stall phases and a long back-pressure.
module ideal_mhd_flux_core_tb
	import imf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483647 - 64'sd1;

	// A moderate cell: v = (1.5, -0.25, 2), B = (0.5, 1, -1), p = 1.
	localparam in_item_t TYPICAL = '{
		vel_x: 32'sh0001_8000, vel_y: 32'shFFFF_C000, vel_z: 32'sh0002_0000,
		field_x: 32'sh0000_8000, field_y: 32'sh0001_0000, field_z: 32'shFFFF_0000,
		gas_pressure: 32'sh0001_0000, mom_x: 32'sh0003_0000, mom_y: 32'shFFFF_8000,
		mom_z: 32'sh0000_4000, total_energy: 32'sh0005_0000, last_cell: 1'b0
	};

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	logic [1:0] cfg_wdata = DIR_X;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// Predictor copy of the direction register, expected results and run bookkeeping.
	logic [1:0] flux_dir = DIR_X;
	out_item_t  flux_due [$];
	int         mismatches = 0;
	int         stall_pct  = 0;
	int         hold_req   = 0;

	// One row of the directed table; want is used only where typed is set.
	typedef struct {
		bit         load;
		logic [1:0] dir;
		in_item_t   stim;
		bit         typed;
		out_item_t  want;
	} vec_t;

	vec_t dir_tab [20] = '{
		'{1'b1, DIR_X, '{default: '0}, 1'b1, '{default: '0}},
		'{1'b0, DIR_X, '{last_cell: 1'b1, default: '0}, 1'b1, '{last_out: 1'b1, default: '0}},
		'{1'b0, DIR_X, '{gas_pressure: 32'sh0003_0000, default: '0}, 1'b1,
			'{total_pressure: 32'sh0003_0000, default: '0}},
		'{1'b0, DIR_X, '{mom_x: Q_MAX, default: '0}, 1'b1, '{flux_mass: Q_MAX, default: '0}},
		'{1'b0, DIR_X, '{mom_x: Q_MIN, default: '0}, 1'b1, '{flux_mass: Q_MIN, default: '0}},
		'{1'b0, DIR_X, TYPICAL, 1'b0, '0},
		'{1'b0, DIR_X, '{default: Q_MAX}, 1'b0, '0},
		'{1'b0, DIR_X, '{default: Q_MIN}, 1'b0, '0},
		'{1'b0, DIR_X, '{default: '1}, 1'b0, '0},
		'{1'b0, DIR_X, '{gas_pressure: Q_MAX, field_x: Q_MAX, field_y: Q_MAX,
			field_z: Q_MAX, default: '0}, 1'b0, '0},
		'{1'b0, DIR_X, '{vel_x: Q_MAX, vel_y: Q_MAX, vel_z: Q_MAX, field_x: Q_MAX,
			field_y: Q_MAX, field_z: Q_MAX, default: '0}, 1'b0, '0},
		'{1'b1, DIR_NONE, TYPICAL, 1'b0, '0},
		'{1'b1, DIR_Y, TYPICAL, 1'b0, '0},
		'{1'b0, DIR_Y, '{default: Q_MAX}, 1'b0, '0},
		'{1'b0, DIR_Y, '{mom_y: Q_MIN, last_cell: 1'b1, default: '0}, 1'b1,
			'{flux_mass: Q_MIN, last_out: 1'b1, default: '0}},
		'{1'b1, DIR_Z, TYPICAL, 1'b0, '0},
		'{1'b0, DIR_Z, '{default: Q_MIN}, 1'b0, '0},
		'{1'b0, DIR_Z, '{vel_z: 32'shFFFF_FFFF, mom_x: 32'sh0000_0001,
			field_x: 32'sh0000_0003, default: '0}, 1'b0, '0},
		'{1'b1, DIR_NONE, TYPICAL, 1'b0, '0},
		'{1'b1, DIR_X, '{vel_x: 32'shFFFF_FFFF, mom_y: 32'sh0000_0001,
			field_y: 32'sh0000_0003, default: '0}, 1'b0, '0}
	};

	ideal_mhd_flux_core #(.FRAC_BITS(FRAC)) uut (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.in_valid, .in_ready, .in_item,
		.out_valid, .out_ready, .out_item
	);

	// Free-running clock, 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Exact product, then floor division by the fixed-point scale.
	function automatic longint prod_q(input longint a, input longint b);
		return (a * b) >>> FRAC;
	endfunction

	// Clamp to the 32-bit signed range, flagging any clamp.
	function automatic longint clamp32(input longint v, inout bit ovf);
		if (v > WORD_MAX) begin
			ovf = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			ovf = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	// Flux vector of one cell normal to direction d.
	function automatic out_item_t predict_flux(input in_item_t ci, input logic [1:0] d);
		longint    vel [3];
		longint    fld [3];
		longint    mom [3];
		longint    fmv [3];
		longint    fbv [3];
		longint    vn, bn, ptot, vb, en;
		logic [63:0] sq;
		bit        ovf;
		int        n;
		out_item_t r;
		vel[0] = ci.vel_x;   vel[1] = ci.vel_y;   vel[2] = ci.vel_z;
		fld[0] = ci.field_x; fld[1] = ci.field_y; fld[2] = ci.field_z;
		mom[0] = ci.mom_x;   mom[1] = ci.mom_y;   mom[2] = ci.mom_z;
		n = int'(d);
		vn = vel[n];
		bn = fld[n];
		ovf = 1'b0;
		// Half of B squared is taken from the exact sum of squares.
		sq = '0;
		for (int k = 0; k < 3; k++)
			sq += 64'(fld[k] * fld[k]);
		ptot = clamp32(longint'(ci.gas_pressure) + longint'(sq >> (FRAC + 1)), ovf);
		vb = 0;
		for (int k = 0; k < 3; k++)
			vb += prod_q(vel[k], fld[k]);
		vb = clamp32(vb, ovf);
		for (int k = 0; k < 3; k++) begin
			fmv[k] = clamp32(prod_q(vn, mom[k]) - prod_q(bn, fld[k]), ovf);
			fbv[k] = 0;
			if (k != n)
				fbv[k] = clamp32(prod_q(vn, fld[k]) - prod_q(bn, vel[k]), ovf);
		end
		en = clamp32(prod_q(ci.total_energy, vn) + prod_q(ptot, vn) - prod_q(bn, vb), ovf);
		r.flux_mass      = 32'(mom[n]);
		r.flux_mom_x     = 32'(fmv[0]);
		r.flux_mom_y     = 32'(fmv[1]);
		r.flux_mom_z     = 32'(fmv[2]);
		r.flux_field_x   = 32'(fbv[0]);
		r.flux_field_y   = 32'(fbv[1]);
		r.flux_field_z   = 32'(fbv[2]);
		r.flux_energy    = 32'(en);
		r.total_pressure = 32'(ptot);
		r.overflow       = ovf;
		r.last_out       = ci.last_cell;
		return r;
	endfunction

	// Mostly modest magnitudes, with full-range words and extremes mixed in.
	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(9))
			0: begin
				return $urandom;
			end
			1: begin
				case ($urandom_range(3))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default: begin
				return $signed($urandom_range(32'h003F_FFFF)) - 32'sh0020_0000;
			end
		endcase
	endfunction

	function automatic in_item_t rand_stim();
		in_item_t s;
		s.vel_x        = rand_word();
		s.vel_y        = rand_word();
		s.vel_z        = rand_word();
		s.field_x      = rand_word();
		s.field_y      = rand_word();
		s.field_z      = rand_word();
		s.gas_pressure = rand_word();
		s.mom_x        = rand_word();
		s.mom_y        = rand_word();
		s.mom_z        = rand_word();
		s.total_energy = rand_word();
		s.last_cell    = ($urandom_range(7) == 0);
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// Offer one request after a random gap and record its expected result once taken.
	task automatic send_req(input in_item_t stim, input int idle_pct, input bit typed,
			input out_item_t want);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= stim;
		do @(posedge clk); while (!in_ready);
		flux_due.push_back(typed ? want : predict_flux(stim, flux_dir));
	endtask

	// Stop offering and wait until every expected result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (flux_due.size() != 0);
	endtask

	// Register write; a code above z leaves the direction unchanged.
	task automatic write_dir(input logic [1:0] d);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (d != DIR_NONE)
			flux_dir = d;
	endtask

	// Receiver: checks each accepted result, then picks the ready for the next cycle.
	initial begin
		int        hold_left;
		out_item_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (flux_due.size() == 0) begin
					report_mismatch("result arrived with none expected");
				end else begin
					want = flux_due.pop_front();
					check_field("flux_mass", out_item.flux_mass, want.flux_mass);
					check_field("flux_mom_x", out_item.flux_mom_x, want.flux_mom_x);
					check_field("flux_mom_y", out_item.flux_mom_y, want.flux_mom_y);
					check_field("flux_mom_z", out_item.flux_mom_z, want.flux_mom_z);
					check_field("flux_field_x", out_item.flux_field_x, want.flux_field_x);
					check_field("flux_field_y", out_item.flux_field_y, want.flux_field_y);
					check_field("flux_field_z", out_item.flux_field_z, want.flux_field_z);
					check_field("flux_energy", out_item.flux_energy, want.flux_energy);
					check_field("total_pressure", out_item.total_pressure,
						want.total_pressure);
					check_field("overflow", 32'(out_item.overflow), 32'(want.overflow));
					check_field("last_out", 32'(out_item.last_out), 32'(want.last_out));
				end
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Main sequence: reset, directed table, random phases, back-pressure, verdict.
	initial begin
		int         idle_tab  [4];
		int         stall_tab [4];
		logic [1:0] phase_dir [4];
		idle_tab  = '{0, 79, 0, 34};
		stall_tab = '{0, 0, 79, 34};
		phase_dir = '{DIR_X, DIR_Y, DIR_Z, DIR_X};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table: extremes, every direction and the ignored write.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].load) begin
				settle();
				write_dir(dir_tab[i].dir);
			end
			send_req(dir_tab[i].stim, 0, dir_tab[i].typed, dir_tab[i].want);
		end

		// Random phases with differing idle and stall rates.
		for (int p = 0; p < 4; p++) begin
			settle();
			if (p == 3)
				phase_dir[p] = 2'($urandom_range(2));
			write_dir(phase_dir[p]);
			stall_pct = stall_tab[p];
			repeat (170) send_req(rand_stim(), idle_tab[p], 1'b0, '0);
		end

		// Long hold on the output so the pipeline fills and stalls its input.
		settle();
		write_dir(DIR_NONE);
		stall_pct = 0;
		hold_req  = 300;
		repeat (40) send_req(rand_stim(), 0, 1'b0, '0);
		settle();
		repeat (20) send_req(rand_stim(), 0, 1'b0, '0);

		settle();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && flux_due.size() == 0) begin
			$display("PASS ideal_mhd_flux_core");
		end else begin
			$display("FAIL ideal_mhd_flux_core");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("FAIL ideal_mhd_flux_core");
		$finish;
	end

endmodule
